// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL of the codec, included by its top-level file.
// Depends on nothing; each macro expects i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge outside reset.
`define ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication, sampled at the rising clock edge outside reset.
`define ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ----- rtl/b64lf_pkg.sv -----
// Types, group record and alphabet functions of the LSB-first Base64 codec.
// Used by the front, queue, back and top-level modules; depends on nothing.
package b64lf_pkg;

    typedef enum logic [1:0] {
        K_ENC = 2'd0,
        K_DEC = 2'd1,
        K_ERR = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [23:0] bits;
        logic        last;
        logic        err;
    } t_grp;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_SLASH = 8'd47;
    localparam logic [6:0] DEC_BAD  = 7'd64;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return w + 8'd65;
        end else if (v < 6'd52) begin
            return w + 8'd71;
        end else if (v < 6'd62) begin
            return w - 8'd4;
        end else if (v == 6'd62) begin
            return CH_PLUS;
        end
        return CH_SLASH;
    endfunction

    // Bit 6 of the result flags a character outside the alphabet.
    function automatic logic [6:0] dec_value(input logic [7:0] c);
        if (c >= 8'd65 && c <= 8'd90) begin
            return 7'(c - 8'd65);
        end else if (c >= 8'd97 && c <= 8'd122) begin
            return 7'(c - 8'd71);
        end else if (c >= 8'd48 && c <= 8'd57) begin
            return 7'(c + 8'd4);
        end else if (c == CH_PLUS) begin
            return 7'd62;
        end else if (c == CH_SLASH) begin
            return 7'd63;
        end
        return DEC_BAD;
    endfunction

endpackage

// ----- rtl/b64lf_front.sv -----
// Front part of the codec: accepts requests, gathers groups and classifies them.
// Depends on b64lf_pkg; pushes one group record per finished group into the queue.
module b64lf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_in_data,
    input  logic              i_in_last,
    input  b64lf_pkg::t_q_stat i_q_stat,
    output logic              o_push,
    output b64lf_pkg::t_grp   o_grp
);
    import b64lf_pkg::*;

    logic        r_mode, n_mode;
    logic [23:0] r_bits, n_bits;
    logic [1:0]  r_cnt, n_cnt;
    logic        r_bad, n_bad;

    logic        accept;
    logic [6:0]  dv;
    logic [5:0]  v6;
    logic [23:0] enc_bits;
    logic [23:0] dec_bits;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;
    assign dv      = dec_value(i_in_data);
    assign v6      = dv[6] ? 6'd0 : dv[5:0];
    assign enc_bits = r_bits | (24'(i_in_data) << {r_cnt, 3'b000});
    assign dec_bits = r_bits | (24'(v6) << (5'(r_cnt) * 5'd6));

    always_comb begin
        o_push = 1'b0;
        o_grp  = '{kind: K_ERR, bits: 24'd0, last: 1'b1, err: 1'b1};
        n_mode = r_mode;
        n_bits = r_bits;
        n_cnt  = r_cnt;
        n_bad  = r_bad;
        if (i_cfg_we) begin
            n_mode = i_cfg_wdata;
            n_bits = '0;
            n_cnt  = '0;
            n_bad  = 1'b0;
        end else if (accept) begin
            if (!r_mode) begin
                if (r_cnt == 2'd2 || i_in_last) begin
                    o_push = 1'b1;
                    o_grp  = '{kind: K_ENC, bits: enc_bits, last: i_in_last, err: 1'b0};
                    n_bits = '0;
                    n_cnt  = '0;
                end else begin
                    n_bits = enc_bits;
                    n_cnt  = 2'(r_cnt + 2'd1);
                end
            end else begin
                if (r_cnt == 2'd3) begin
                    o_push = 1'b1;
                    o_grp  = '{kind: K_DEC, bits: dec_bits, last: i_in_last,
                               err: r_bad | dv[6]};
                    n_bits = '0;
                    n_cnt  = '0;
                    n_bad  = 1'b0;
                end else if (i_in_last) begin
                    o_push = 1'b1;
                    n_bits = '0;
                    n_cnt  = '0;
                    n_bad  = 1'b0;
                end else begin
                    n_bits = dec_bits;
                    n_cnt  = 2'(r_cnt + 2'd1);
                    n_bad  = r_bad | dv[6];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_bits <= '0;
            r_cnt  <= '0;
            r_bad  <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_bits <= n_bits;
            r_cnt  <= n_cnt;
            r_bad  <= n_bad;
        end
    end

endmodule

// ----- rtl/b64lf_queue.sv -----
// Short queue of group records between the front and back parts.
// Depends on b64lf_pkg for the record and status types.
module b64lf_queue #(
    parameter int DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  b64lf_pkg::t_grp     i_grp,
    input  logic                i_pop,
    output b64lf_pkg::t_grp     o_head,
    output b64lf_pkg::t_q_stat  o_stat
);
    import b64lf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_grp          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : AW'(r_wr_ptr + 1'b1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : AW'(r_rd_ptr + 1'b1);
        end
        if (i_push && !i_pop) begin
            n_count = CW'(r_count + 1'b1);
        end else if (!i_push && i_pop) begin
            n_count = CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- rtl/b64lf_back.sv -----
// Back part of the codec: takes group records and sends their results one per cycle
// while i_ready allows. Depends on b64lf_pkg; drives the result output register.
module b64lf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  b64lf_pkg::t_grp    i_head,
    input  b64lf_pkg::t_q_stat i_q_stat,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_out_data,
    output logic               o_out_last,
    output logic               o_out_error
);
    import b64lf_pkg::*;

    logic       r_have, n_have;
    t_grp       r_rec, n_rec;
    logic [1:0] r_idx, n_idx;
    logic       r_ovalid, n_ovalid;
    logic [7:0] r_odata, n_odata;
    logic       r_olast, n_olast;
    logic       r_oerr, n_oerr;

    logic       load;
    logic       final_el;
    logic [7:0] el_data;
    logic       el_last;
    logic       el_err;
    logic [23:0] enc_sh;
    logic [23:0] dec_sh;

    assign enc_sh = r_rec.bits >> (5'(r_idx) * 5'd6);
    assign dec_sh = r_rec.bits >> {r_idx, 3'b000};

    always_comb begin
        unique case (r_rec.kind)
            K_ENC: begin
                el_data  = enc_char(enc_sh[5:0]);
                el_last  = (r_idx == 2'd3) && r_rec.last;
                el_err   = 1'b0;
                final_el = (r_idx == 2'd3);
            end
            K_DEC: begin
                el_data  = dec_sh[7:0];
                el_last  = (r_idx == 2'd2) && r_rec.last;
                el_err   = r_rec.err;
                final_el = (r_idx == 2'd2);
            end
            default: begin
                el_data  = 8'd0;
                el_last  = 1'b1;
                el_err   = 1'b1;
                final_el = 1'b1;
            end
        endcase
    end

    assign load  = r_have && (!r_ovalid || i_ready);
    assign o_pop = !i_q_stat.empty && (!r_have || (load && final_el));

    always_comb begin
        n_have   = r_have;
        n_rec    = r_rec;
        n_idx    = r_idx;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        n_olast  = r_olast;
        n_oerr   = r_oerr;
        if (o_pop) begin
            n_have = 1'b1;
            n_rec  = i_head;
            n_idx  = '0;
        end else if (load && final_el) begin
            n_have = 1'b0;
        end else if (load) begin
            n_idx = 2'(r_idx + 2'd1);
        end
        if (load) begin
            n_ovalid = 1'b1;
            n_odata  = el_data;
            n_olast  = el_last;
            n_oerr   = el_err;
        end else if (i_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec   <= n_rec;
        r_odata <= n_odata;
        r_olast <= n_olast;
        r_oerr  <= n_oerr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have   <= 1'b0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_have   <= n_have;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_out_data  = r_odata;
    assign o_out_last  = r_olast;
    assign o_out_error = r_oerr;

endmodule

// ----- rtl/base64_lsb_first_codec_core.sv -----
// Top level of the LSB-first Base64 codec: front, group queue and back part.
// Depends on b64lf_pkg, assert_macros.svh and the b64lf_front/queue/back modules.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+------------------------------------
//  input    | in        | i_valid / o_ready  | i_in_data, i_in_last
//  result   | out       | o_valid / i_ready  | o_out_data, o_out_last, o_out_error
//  config   | in        | i_cfg_we           | i_cfg_wdata (mode)
//
// A request is taken in every cycle while the group queue has room. The back part sends
// one result per cycle from its output register while i_ready is high; decoding then
// sustains one character per cycle, and encoding three bytes per four results. A group
// passes the queue, the back record register and the output register. Reset is synchronous
// and clears all control state; a result-side stall fills the queue and then drops o_ready.
`include "assert_macros.svh"

module base64_lsb_first_codec_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_data,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_data,
    output logic       o_out_last,
    output logic       o_out_error
);
    import b64lf_pkg::*;

    t_grp    grp_in;
    t_grp    grp_head;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    b64lf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in_data   (i_in_data),
        .i_in_last   (i_in_last),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_grp       (grp_in)
    );

    b64lf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_grp   (grp_in),
        .i_pop   (pop),
        .o_head  (grp_head),
        .o_stat  (q_stat)
    );

    b64lf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (grp_head),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_data  (o_out_data),
        .o_out_last  (o_out_last),
        .o_out_error (o_out_error)
    );

    `ASSERT_IMP(a_no_push_full, push, !q_stat.full)
    `ASSERT_IMP(a_no_pop_empty, pop, !q_stat.empty)
    `ASSERT_IMP(a_full_not_empty, q_stat.full, !q_stat.empty)
    `ASSERT_NXT(a_push_fills, push && !pop, !q_stat.empty)

endmodule

// ----- tb/tb_base64_lsb_first_codec_core.sv -----
// Self-checking testbench for base64_lsb_first_codec_core in encode and decode mode.
// Depends only on the codec RTL; the expected results come from a scoreboard in this file.
`timescale 1ns / 100ps

module tb_base64_lsb_first_codec_core;

    localparam logic       MODE_ENCODE   = 1'b0;
    localparam logic       MODE_DECODE   = 1'b1;
    localparam logic [7:0] PAD_CHAR      = 8'h3D;
    localparam int         SETTLE_CYCLES = 12;
    localparam int         LONG_HOLD     = 100;
    localparam int         STALL_LIMIT   = 2000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } t_b64_result;

    class b64_scoreboard;
        string         alphabet;
        logic          mode;
        logic [23:0]   group;
        int unsigned   fill;
        logic          bad;
        t_b64_result   expected_q[$];
        int            errors;
        int            checked;

        function new();
            alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            mode     = MODE_ENCODE;
            errors   = 0;
            checked  = 0;
            clear_group();
        endfunction

        function void clear_group();
            group = '0;
            fill  = 0;
            bad   = 1'b0;
        endfunction

        function void set_mode(logic m);
            mode = m;
            clear_group();
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [7:0] char_of(logic [5:0] v);
            return 8'(alphabet[v]);
        endfunction

        function int unsigned sextet_of(logic [7:0] c);
            for (int k = 0; k < 64; k++) begin
                if (8'(alphabet[k]) == c) begin
                    return k;
                end
            end
            return 64;
        endfunction

        function void push_result(logic [7:0] d, logic l, logic e);
            t_b64_result r;
            r.data = d;
            r.last = l;
            r.err  = e;
            expected_q.push_back(r);
        endfunction

        function void note_request(logic [7:0] d, logic l);
            int unsigned v;
            if (mode == MODE_ENCODE) begin
                group = group | (24'(d) << (8 * fill));
                fill++;
                if (fill == 3 || l) begin
                    for (int j = 0; j < 4; j++) begin
                        push_result(char_of(group[6*j +: 6]), (j == 3) ? l : 1'b0, 1'b0);
                    end
                    clear_group();
                end
            end else begin
                v = sextet_of(d);
                if (v > 63) begin
                    v   = 0;
                    bad = 1'b1;
                end
                group = group | (24'(v) << (6 * fill));
                if (fill == 3) begin
                    for (int j = 0; j < 3; j++) begin
                        push_result(group[8*j +: 8], (j == 2) ? l : 1'b0, bad);
                    end
                    clear_group();
                end else if (l) begin
                    push_result(8'h00, 1'b1, 1'b1);
                    clear_group();
                end else begin
                    fill++;
                end
            end
        endfunction

        function void check_result(logic [7:0] d, logic l, logic e);
            t_b64_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual data=%h last=%b error=%b",
                         $time, d, l, e);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (d !== want.data) begin
                $display("%0t: out_data expected %h actual %h", $time, want.data, d);
                errors++;
            end
            if (l !== want.last) begin
                $display("%0t: out_last expected %b actual %b", $time, want.last, l);
                errors++;
            end
            if (e !== want.err) begin
                $display("%0t: out_error expected %b actual %b", $time, want.err, e);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_wdata = 1'b0;
    logic       i_valid     = 1'b0;
    logic       o_ready;
    logic [7:0] i_in_data   = 8'h00;
    logic       i_in_last   = 1'b0;
    logic       o_valid;
    logic       i_ready     = 1'b0;
    logic [7:0] o_out_data;
    logic       o_out_last;
    logic       o_out_error;

    b64_scoreboard board;
    int unsigned   send_idle_pct  = 0;
    int unsigned   recv_stall_pct = 0;
    logic          hold_active    = 1'b0;
    int            items_sent     = 0;
    int            quiet_cycles   = 0;

    base64_lsb_first_codec_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in_data   (i_in_data),
        .i_in_last   (i_in_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_data  (o_out_data),
        .o_out_last  (o_out_last),
        .o_out_error (o_out_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            board.check_result(o_out_data, o_out_last, o_out_error);
        end
        if (hold_active) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_request(input logic [7:0] d, input logic l);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_data <= d;
        i_in_last <= l;
        do @(posedge i_clk); while (!o_ready);
        board.note_request(d, l);
        items_sent++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.set_mode(m);
    endtask

    task automatic send_encode_message();
        int unsigned len;
        len = ($urandom_range(9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 9);
        for (int i = 0; i < len; i++) begin
            send_request(8'($urandom_range(255)), i == len - 1);
        end
    endtask

    // Mostly clean messages of whole groups; some carry bad characters, some are cut short.
    task automatic send_decode_message();
        int unsigned flavor;
        int unsigned len;
        logic [7:0]  c;
        flavor = $urandom_range(99);
        len    = 4 * $urandom_range(1, 3);
        if (flavor >= 85) begin
            len = len - $urandom_range(1, 3);
        end
        for (int i = 0; i < len; i++) begin
            c = 8'(board.alphabet[$urandom_range(63)]);
            if (flavor >= 60 && flavor < 85 && $urandom_range(5) == 0) begin
                c = $urandom_range(1) ? PAD_CHAR : 8'($urandom_range(255));
            end
            send_request(c, i == len - 1);
        end
    endtask

    task automatic random_traffic(input int n);
        int target;
        target = items_sent + n;
        while (items_sent < target) begin
            if ($urandom_range(99) < 8) begin
                send_request(8'($urandom_range(255)), 1'b0);
            end else if (board.mode == MODE_ENCODE) begin
                send_encode_message();
            end else begin
                send_decode_message();
            end
        end
    endtask

    task automatic run_phase(input logic m, input int unsigned sp, input int unsigned rp,
                             input int n);
        settle();
        write_mode(m);
        send_idle_pct  = sp;
        recv_stall_pct = rp;
        random_traffic(n);
    endtask

    initial begin
        board = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(8'h00, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(8'hFF, 1'b1);
        send_request(8'h01, 1'b1);
        send_request(8'h80, 1'b0);
        send_request(8'h7F, 1'b1);
        send_request(8'h12, 1'b0);
        send_request(8'h34, 1'b0);
        settle();

        // The two open bytes above must be dropped by this write.
        write_mode(MODE_DECODE);
        send_request("A", 1'b0);
        send_request("/", 1'b0);
        send_request("+", 1'b0);
        send_request("9", 1'b0);
        send_request("z", 1'b0);
        send_request("a", 1'b0);
        send_request("Z", 1'b0);
        send_request("0", 1'b1);
        send_request(PAD_CHAR, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request("B", 1'b0);
        send_request("Q", 1'b0);
        send_request("w", 1'b1);
        send_request("x", 1'b1);

        run_phase(MODE_ENCODE, 0, 0, 85);
        run_phase(MODE_DECODE, 87, 0, 85);
        run_phase(MODE_ENCODE, 0, 87, 85);
        run_phase(MODE_DECODE, 26, 26, 85);

        settle();
        write_mode(MODE_ENCODE);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_active <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_active <= 1'b0;
            end
            random_traffic(60);
        join

        settle();
        board.errors += board.pending();
        $display("Sent %0d requests and checked %0d results in both modes,", items_sent,
                 board.checked);
        $display("with sender gaps, receiver stalls, a long hold-off and mode changes.");
        if (board.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
